[rtl/core/ksrmp_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the k-step recurrence matrix power block.
// Used by the cell chain, the top level and the checker; depends on nothing.
package ksrmp_pkg;

  localparam int VAL_W = 17;
  localparam int MOD_W = VAL_W + 1;
  localparam int ORDER_W = 3;
  localparam int ORDER_LIMIT_DEF = 7;
  localparam int INDEX_WIDTH_DEF = 48;
  localparam logic [VAL_W-1:0] MODULUS_RESET = 17'd100007;

  // One product term travelling down the chain of modular multiply cells.
  typedef struct packed {
    logic             vld;
    logic             first;
    logic             last;
    logic [VAL_W-1:0] r;
    logic [VAL_W-1:0] x;
    logic [VAL_W-1:0] y;
  } cell_data_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_NEXT,
    ST_ISSUE,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_SQR,
    OP_SUM
  } op_t;

  // Order reduced by the order limit with at most four subtractions.
  function automatic logic [ORDER_W-1:0] reduce_order(input logic [ORDER_W-1:0] b,
                                                      input int limit);
    logic [ORDER_W-1:0] v;
    v = b;
    for (int i = 0; i < 4; i++) begin
      if (int'(v) >= limit) begin
        v = ORDER_W'(int'(v) - limit);
      end
    end
    return v;
  endfunction

endpackage

[rtl/core/ksrmp_ram.sv]
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package dependency.
module ksrmp_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/ksrmp_cell.sv]
`timescale 1ns / 1ps
// One step of an interleaved modular multiply: r = (2r + y_msb * x) mod m.
// Depends on ksrmp_pkg for the cell data type.
module ksrmp_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [ksrmp_pkg::MOD_W-1:0]   mod_eff,
  input  ksrmp_pkg::cell_data_t         d_in,
  output ksrmp_pkg::cell_data_t         d_out
);
  import ksrmp_pkg::*;

  logic [VAL_W+1:0] t;
  logic [VAL_W+1:0] m1;
  logic [VAL_W+1:0] m2;
  logic [VAL_W+1:0] t_red;

  assign m1 = {1'b0, mod_eff};
  assign m2 = {mod_eff, 1'b0};

  // Since r < m and x < m, the sum stays below 3m and two compares suffice.
  always_comb begin
    t = {1'b0, d_in.r, 1'b0} + (d_in.y[VAL_W-1] ? {2'b0, d_in.x} : '0);
    if (t >= m2) begin
      t_red = t - m2;
    end else if (t >= m1) begin
      t_red = t - m1;
    end else begin
      t_red = t;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_out.vld <= 1'b0;
    end else begin
      d_out.vld <= d_in.vld;
    end
    d_out.first <= d_in.first;
    d_out.last  <= d_in.last;
    d_out.r     <= t_red[VAL_W-1:0];
    d_out.x     <= d_in.x;
    d_out.y     <= {d_in.y[VAL_W-2:0], 1'b0};
  end

endmodule

[rtl/core/ksrmp_chain.sv]
`timescale 1ns / 1ps
// Row of modular multiply cells, one per multiplier bit, and the modular
// accumulator behind it. Depends on ksrmp_pkg and ksrmp_cell.
module ksrmp_chain (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [ksrmp_pkg::MOD_W-1:0]   mod_eff,
  input  ksrmp_pkg::cell_data_t         d_in,
  output logic                          res_valid,
  output logic [ksrmp_pkg::VAL_W-1:0]   res_value
);
  import ksrmp_pkg::*;

  cell_data_t       stage [VAL_W+1];
  logic [MOD_W-1:0] s_raw;
  logic [MOD_W-1:0] s_red;
  logic [VAL_W-1:0] acc;

  assign stage[0] = d_in;

  for (genvar i = 0; i < VAL_W; i++) begin : g_cell
    ksrmp_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .mod_eff (mod_eff),
      .d_in    (stage[i]),
      .d_out   (stage[i+1])
    );
  end

  always_comb begin
    s_raw = (stage[VAL_W].first ? '0 : {1'b0, acc}) + {1'b0, stage[VAL_W].r};
    s_red = (s_raw >= mod_eff) ? s_raw - mod_eff : s_raw;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= stage[VAL_W].vld && stage[VAL_W].last;
    end
    if (stage[VAL_W].vld) begin
      acc <= s_red[VAL_W-1:0];
    end
    res_value <= s_red[VAL_W-1:0];
  end

endmodule

[rtl/core/kstep_recurrence_matrix_power_top.sv]
`timescale 1ns / 1ps
// Term a of the order-b Fibonacci-like sequence modulo a configured modulus,
// by square-and-multiply of the companion matrix. Depends on ksrmp_pkg,
// ksrmp_ram and ksrmp_chain.
// Short cases (a <= b, or an order that reduces to 0) skip the matrix work.
// Otherwise the identity and companion matrices are written first, then
// each matrix product issues n^3 terms and drains the chain, over about
// 2*log2(a-b) products, and a final row sum issues n terms. One transaction
// at a time; the 17-cell multiply chain takes one term per cycle.
// Synchronous reset clears control and sets the modulus to 100007.
module kstep_recurrence_matrix_power_top #(
  parameter int ORDER_LIMIT = ksrmp_pkg::ORDER_LIMIT_DEF,
  parameter int INDEX_WIDTH = ksrmp_pkg::INDEX_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  output logic                            req_stall,
  input  logic [INDEX_WIDTH-1:0]          term_index,
  input  logic [ksrmp_pkg::ORDER_W-1:0]   order,
  output logic                            rsp_valid,
  input  logic                            rsp_stall,
  output logic [ksrmp_pkg::VAL_W-1:0]     term_value,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ksrmp_pkg::VAL_W-1:0]     cfg_modulus
);
  import ksrmp_pkg::*;

  localparam int MAT_DIM = (ORDER_LIMIT > 8) ? 7 : ORDER_LIMIT - 1;
  localparam int IDX_W   = (MAT_DIM > 1) ? $clog2(MAT_DIM) : 1;
  localparam int AW      = 2 * IDX_W + 1;
  localparam int DEPTH   = 1 << AW;

  state_t state, state_next;
  op_t    op;

  logic [VAL_W-1:0]       modulus;
  logic [MOD_W-1:0]       mod_eff;
  logic [VAL_W-1:0]       one_val;
  logic [INDEX_WIDTH-1:0] e;
  logic [INDEX_WIDTH-1:0] e_shift;
  logic [IDX_W-1:0]       n_last;
  logic                   mul_done;
  logic                   bank_a;
  logic                   bank_b;
  logic [IDX_W-1:0]       ir, ic, ik;
  logic [IDX_W-1:0]       wr_r, wr_c;
  logic [2*IDX_W-1:0]     init_cnt;
  logic [VAL_W-1:0]       result;
  logic                   iss_vld, iss_first, iss_last;

  logic                   accept;
  logic                   short_case;
  logic [ORDER_W-1:0]     n_red;
  logic                   issue_go;
  logic                   issue_end;
  logic                   init_go;
  logic                   init_end;
  logic                   out_load;
  logic                   wr_final;
  logic                   drain_done;
  logic                   res_valid;
  logic [VAL_W-1:0]       res_value;

  logic                   we_a, we_b;
  logic [AW-1:0]          waddr_a, waddr_b;
  logic [VAL_W-1:0]       wdata_a, wdata_b;
  logic [VAL_W-1:0]       a_rdata, b0_rdata, b1_rdata;
  logic [IDX_W-1:0]       init_r, init_c;
  cell_data_t             chain_in;

  assign mod_eff    = {(modulus == '0), modulus};
  assign one_val    = (modulus == VAL_W'(1)) ? '0 : VAL_W'(1);
  assign accept     = req_valid && !req_stall;
  assign short_case = term_index <= INDEX_WIDTH'(order);
  assign n_red      = reduce_order(order, ORDER_LIMIT);
  assign e_shift    = e >> 1;
  assign cfg_ready  = 1'b1;
  assign init_r     = init_cnt[2*IDX_W-1:IDX_W];
  assign init_c     = init_cnt[IDX_W-1:0];

  assign issue_end = (op == OP_SUM) ? (ik == n_last)
                                    : (ik == n_last && ic == n_last && ir == n_last);
  assign init_end  = (init_cnt == '1);
  assign wr_final  = (wr_r == n_last) && (wr_c == n_last);
  assign drain_done = res_valid && ((op == OP_SUM) || wr_final);

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (short_case || n_red == '0) ? ST_DONE : ST_INIT;
        end
      end
      ST_INIT: begin
        if (init_end) begin
          state_next = ST_NEXT;
        end
      end
      ST_NEXT:  state_next = ST_ISSUE;
      ST_ISSUE: begin
        if (issue_end) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (drain_done) begin
          state_next = (op == OP_SUM) ? ST_DONE : ST_NEXT;
        end
      end
      ST_DONE: begin
        if (!rsp_valid || !rsp_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State-decoded controls.
  always_comb begin
    req_stall = 1'b1;
    issue_go  = 1'b0;
    init_go   = 1'b0;
    out_load  = 1'b0;
    unique case (state)
      ST_IDLE:  req_stall = 1'b0;
      ST_INIT:  init_go = 1'b1;
      ST_ISSUE: issue_go = 1'b1;
      ST_DONE:  out_load = !rsp_valid || !rsp_stall;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= MODULUS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      modulus <= cfg_modulus;
    end
  end

  // Sequencer: exponent walk, counters and bank selects.
  always_ff @(posedge clk) begin
    if (rst) begin
      op       <= OP_SUM;
      mul_done <= 1'b0;
      bank_a   <= 1'b0;
      bank_b   <= 1'b0;
      iss_vld  <= 1'b0;
    end else begin
      iss_vld <= issue_go;
      if (accept) begin
        e        <= term_index - INDEX_WIDTH'(order);
        n_last   <= IDX_W'(n_red - ORDER_W'(1));
        result   <= short_case ? one_val : '0;
        mul_done <= 1'b0;
        bank_a   <= 1'b0;
        bank_b   <= 1'b0;
        init_cnt <= '0;
      end
      if (init_go) begin
        init_cnt <= init_cnt + 1'b1;
      end
      if (state == ST_NEXT) begin
        ir   <= '0;
        ic   <= '0;
        ik   <= '0;
        wr_r <= '0;
        wr_c <= '0;
        if (e == '0) begin
          op <= OP_SUM;
        end else if (e[0] && !mul_done) begin
          op       <= OP_MUL;
          mul_done <= 1'b1;
        end else begin
          e        <= e_shift;
          mul_done <= 1'b0;
          op       <= (e_shift != '0) ? OP_SQR : OP_SUM;
        end
      end
      if (issue_go) begin
        if (ik == n_last) begin
          ik <= '0;
          if (ic == n_last) begin
            ic <= '0;
            ir <= ir + 1'b1;
          end else begin
            ic <= ic + 1'b1;
          end
        end else begin
          ik <= ik + 1'b1;
        end
      end
      if (res_valid) begin
        if (op == OP_SUM) begin
          result <= res_value;
        end else begin
          if (wr_c == n_last) begin
            wr_c <= '0;
            wr_r <= wr_r + 1'b1;
          end else begin
            wr_c <= wr_c + 1'b1;
          end
          if (wr_final && op == OP_MUL) begin
            bank_a <= ~bank_a;
          end
          if (wr_final && op == OP_SQR) begin
            bank_b <= ~bank_b;
          end
        end
      end
    end
    iss_first <= (ik == '0);
    iss_last  <= (ik == n_last);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
    if (out_load) begin
      term_value <= result;
    end
  end

  // Write ports: initial identity and companion matrices, then product results
  // into the idle bank of the destination matrix.
  always_comb begin
    we_a    = 1'b0;
    we_b    = 1'b0;
    waddr_a = {~bank_a, wr_r, wr_c};
    waddr_b = {~bank_b, wr_r, wr_c};
    wdata_a = res_value;
    wdata_b = res_value;
    if (init_go) begin
      we_a    = 1'b1;
      we_b    = 1'b1;
      waddr_a = {1'b0, init_cnt};
      waddr_b = {1'b0, init_cnt};
      wdata_a = (init_r == init_c) ? one_val : '0;
      wdata_b = (init_r == '0 || ({1'b0, init_c} + 1'b1) == {1'b0, init_r})
                ? one_val : '0;
    end else if (res_valid) begin
      we_a = (op == OP_MUL);
      we_b = (op == OP_SQR);
    end
  end

  ksrmp_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_ram_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (waddr_a),
    .wdata (wdata_a),
    .raddr ({bank_a, ir, ik}),
    .rdata (a_rdata)
  );

  // Two copies of the base matrix so a square can read row and column at once.
  ksrmp_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_ram_b0 (
    .clk   (clk),
    .we    (we_b),
    .waddr (waddr_b),
    .wdata (wdata_b),
    .raddr ({bank_b, ir, ik}),
    .rdata (b0_rdata)
  );

  ksrmp_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_ram_b1 (
    .clk   (clk),
    .we    (we_b),
    .waddr (waddr_b),
    .wdata (wdata_b),
    .raddr ({bank_b, ik, ic}),
    .rdata (b1_rdata)
  );

  always_comb begin
    chain_in.vld   = iss_vld;
    chain_in.first = iss_first;
    chain_in.last  = iss_last;
    chain_in.r     = '0;
    chain_in.x     = (op == OP_SQR) ? b0_rdata : a_rdata;
    chain_in.y     = (op == OP_SUM) ? VAL_W'(1) : b1_rdata;
  end

  ksrmp_chain u_chain (
    .clk       (clk),
    .rst       (rst),
    .mod_eff   (mod_eff),
    .d_in      (chain_in),
    .res_valid (res_valid),
    .res_value (res_value)
  );

endmodule

[rtl/core/ksrmp_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for the k-step recurrence matrix power block, bound to
// the top level. Depends on ksrmp_pkg for field widths.
module ksrmp_checker #(
  parameter int INDEX_WIDTH = ksrmp_pkg::INDEX_WIDTH_DEF
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          req_valid,
  input logic                          req_stall,
  input logic [INDEX_WIDTH-1:0]        term_index,
  input logic                          rsp_valid,
  input logic                          rsp_stall,
  input logic [ksrmp_pkg::VAL_W-1:0]   term_value
);
  import ksrmp_pkg::*;

  // A stalled request transaction keeps its index.
  a_req_hold: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_stall) |=> (req_valid && $stable(term_index)))
    else $error("request changed while stalled");

  // A stalled response transaction keeps its value.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (!rst && rsp_valid && rsp_stall) |=> (rsp_valid && $stable(term_value)))
    else $error("response changed while stalled");

  // The block works on one transaction at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (!rst && req_valid && !req_stall) |=> req_stall)
    else $error("request accepted while busy");

  // A response only appears at the end of work, never from the idle state.
  a_rsp_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(req_stall))
    else $error("response produced without an accepted request");

endmodule

bind kstep_recurrence_matrix_power_top ksrmp_checker #(
  .INDEX_WIDTH(INDEX_WIDTH)
) u_ksrmp_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req_valid),
  .req_stall  (req_stall),
  .term_index (term_index),
  .rsp_valid  (rsp_valid),
  .rsp_stall  (rsp_stall),
  .term_value (term_value)
);
